>>> sv/psj_pkg.sv
package psj_pkg;

  // fixed widths of the channel fields
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // defaults for the top level parameters
  localparam int BUFFER_DEPTH_DEF = 6;
  localparam int TIME_BITS_DEF    = 16;

  // a join needs at least this many stored segments
  localparam int JOIN_MIN_FILL = 4;

  // controller to datapath commands
  typedef struct packed {
    logic store;      // write the segments of the accepted beat
    logic join_init;  // clear sums, latch the front level
    logic join_step;  // absorb the front segment and shift the buffer
    logic load_out;   // load the result register
    logic reject;     // the loaded result is a reject
  } psj_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;       // no room for another beat
    logic can_join;   // enough segments and two level changes
    logic join_stop;  // front segment opens the third run
  } psj_sts_t;

endpackage

>>> sv/psj_if.sv
interface psj_in_if;
  logic                     valid;
  logic                     ready;
  logic                     level;
  logic [psj_pkg::IN_W-1:0] period_time;
  logic [psj_pkg::IN_W-1:0] active_time;

  modport source (output valid, output level, output period_time, output active_time,
                  input ready);
  modport sink   (input valid, input level, input period_time, input active_time,
                  output ready);
endinterface

>>> sv/psj_out_if.sv
interface psj_out_if;
  logic                      valid;
  logic                      ready;
  logic [psj_pkg::OUT_W-1:0] joined_period;
  logic [psj_pkg::OUT_W-1:0] joined_high;
  logic                      rejected;

  modport source (output valid, output joined_period, output joined_high, output rejected,
                  input ready);
  modport sink   (input valid, input joined_period, input joined_high, input rejected,
                  output ready);
endinterface

>>> sv/psj_ctrl.sv
module psj_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  psj_pkg::psj_sts_t sts,
  output psj_pkg::psj_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_JOIN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   rej_r, rej_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_fire   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.reject    = rej_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rej_nxt   = sts.full;
          cmd.store = !sts.full;
          state_nxt = sts.full ? ST_EMIT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.can_join) begin
          cmd.join_init = 1'b1;
          state_nxt     = ST_JOIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_JOIN: begin
        if (sts.join_stop) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.join_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/psj_dp.sv
module psj_dp #(
  parameter int BUFFER_DEPTH = psj_pkg::BUFFER_DEPTH_DEF,
  parameter int TIME_BITS    = psj_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_level,
  input  logic [psj_pkg::IN_W-1:0]  in_period_time,
  input  logic [psj_pkg::IN_W-1:0]  in_active_time,
  output logic [psj_pkg::OUT_W-1:0] out_joined_period,
  output logic [psj_pkg::OUT_W-1:0] out_joined_high,
  output logic                      out_rejected,
  input  psj_pkg::psj_cmd_t         cmd,
  output psj_pkg::psj_sts_t         sts
);

  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = psj_pkg::IN_W;
  localparam int OW = psj_pkg::OUT_W;

  logic [TIME_BITS-1:0] seg_time_r [BUFFER_DEPTH];
  logic                 seg_lvl_r  [BUFFER_DEPTH];
  logic [FW-1:0]        fill_r;
  logic [TIME_BITS-1:0] sum_p_r, sum_h_r;
  logic                 last_r, seen_r;
  logic [OW-1:0]        res_p_r, res_h_r;
  logic                 res_rej_r;

  logic                    first_seg, second_seg;
  logic [IW-1:0]           rem_time;
  logic [IW+TIME_BITS-1:0] act_ext, rem_ext;
  logic [TIME_BITS-1:0]    act_t, rem_t;
  logic [FW-1:0]           second_idx;
  logic [BUFFER_DEPTH-1:0] chg;
  logic                    two_chg;
  logic [OW+TIME_BITS-1:0] sum_p_ext, sum_h_ext;

  // split the beat into its segments
  assign first_seg  = !(!in_level && (fill_r == '0));
  assign second_seg = in_period_time > in_active_time;
  assign rem_time   = in_period_time - in_active_time;
  assign act_ext    = {{TIME_BITS{1'b0}}, in_active_time};
  assign rem_ext    = {{TIME_BITS{1'b0}}, rem_time};
  assign act_t      = act_ext[TIME_BITS-1:0];
  assign rem_t      = rem_ext[TIME_BITS-1:0];
  assign second_idx = fill_r + FW'(first_seg);

  // level changes among the stored segments
  always_comb begin
    chg = '0;
    for (int i = 1; i < BUFFER_DEPTH; i++) begin
      chg[i] = (seg_lvl_r[i] != seg_lvl_r[i-1]) && (FW'(i) < fill_r);
    end
  end
  assign two_chg = |(chg & (chg - BUFFER_DEPTH'(1)));

  assign sts.full      = fill_r >= FW'(BUFFER_DEPTH - 1);
  assign sts.can_join  = (fill_r >= FW'(psj_pkg::JOIN_MIN_FILL)) && two_chg;
  assign sts.join_stop = seen_r && (seg_lvl_r[0] != last_r);

  // segment buffer: append on store, shift forward on join step
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        if (first_seg && (FW'(i) == fill_r)) begin
          seg_lvl_r[i]  <= in_level;
          seg_time_r[i] <= act_t;
        end else if (second_seg && (FW'(i) == second_idx)) begin
          seg_lvl_r[i]  <= !in_level;
          seg_time_r[i] <= rem_t;
        end
      end
    end else if (cmd.join_step) begin
      for (int i = 0; i < BUFFER_DEPTH - 1; i++) begin
        seg_lvl_r[i]  <= seg_lvl_r[i+1];
        seg_time_r[i] <= seg_time_r[i+1];
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.store) begin
      fill_r <= fill_r + FW'(first_seg) + FW'(second_seg);
    end else if (cmd.join_step) begin
      fill_r <= fill_r - FW'(1);
    end
  end

  // join accumulators
  always_ff @(posedge clk) begin
    if (cmd.join_init) begin
      sum_p_r <= '0;
      sum_h_r <= '0;
      last_r  <= seg_lvl_r[0];
      seen_r  <= 1'b0;
    end else if (cmd.join_step) begin
      sum_p_r <= sum_p_r + seg_time_r[0];
      if (seg_lvl_r[0]) begin
        sum_h_r <= sum_h_r + seg_time_r[0];
      end
      if (seg_lvl_r[0] != last_r) begin
        seen_r <= 1'b1;
        last_r <= seg_lvl_r[0];
      end
    end
  end

  // result register
  assign sum_p_ext = {{OW{1'b0}}, sum_p_r};
  assign sum_h_ext = {{OW{1'b0}}, sum_h_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_rej_r <= cmd.reject;
      res_p_r   <= cmd.reject ? '0 : sum_p_ext[OW-1:0];
      res_h_r   <= cmd.reject ? '0 : sum_h_ext[OW-1:0];
    end
  end

  assign out_joined_period = res_p_r;
  assign out_joined_high   = res_h_r;
  assign out_rejected      = res_rej_r;

endmodule

>>> sv/pulse_segment_joiner_top.sv
// pulse segment joiner
// in_bus carries one period per beat: level, period_time, active_time. each
// beat becomes up to two segments in a small buffer; once two runs of
// opposite level are complete they are summed and sent on out_bus as
// joined_period / joined_high, and the rest of the buffer moves forward.
// a beat that finds the buffer full is dropped and answered by one result
// with rejected set and zero sums. a beat that completes no join gives no
// result.
// timing: the block takes one beat at a time. a beat with no result frees
// in_ready after one pass through the check state. a reject goes from
// acceptance to the emit state, which loads the output register once it is
// free. a join absorbs from 2 up to BUFFER_DEPTH - 1 segments after the
// check state: it shifts the buffer forward one segment per cycle through a
// single adder pair.
// the result sits in an output register; while the receiver holds ready
// low the block keeps taking beats that produce no result, and one that
// does waits until the register frees up.
// reset (rst_n low, synchronous) empties the buffer and clears out_valid.
module pulse_segment_joiner_top #(
  parameter int BUFFER_DEPTH = psj_pkg::BUFFER_DEPTH_DEF,
  parameter int TIME_BITS    = psj_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  psj_in_if.sink           in_bus,
  psj_out_if.source        out_bus
);

  psj_pkg::psj_cmd_t cmd;
  psj_pkg::psj_sts_t sts;

  psj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  psj_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_level          (in_bus.level),
    .in_period_time    (in_bus.period_time),
    .in_active_time    (in_bus.active_time),
    .out_joined_period (out_bus.joined_period),
    .out_joined_high   (out_bus.joined_high),
    .out_rejected      (out_bus.rejected),
    .cmd               (cmd),
    .sts               (sts)
  );

  // a reject carries zero sums
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.rejected |->
      (out_bus.joined_period == '0) && (out_bus.joined_high == '0))
    else $error("reject result with nonzero sums");

  // one beat at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> !in_bus.ready)
    else $error("beat accepted while busy");

  // loading the result register raises out valid
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_bus.valid)
    else $error("result loaded without valid");

  // store never coincides with join step or load out
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.store && (cmd.join_step || cmd.load_out)))
    else $error("conflicting datapath commands");

endmodule
